// ===== src/laiir_pkg.sv =====
// ----------------------------------------------------------------------------
// laiir_pkg
// Widths, register indexes and the shared Q9 multiply for the look-ahead
// first-order IIR filter.
// ----------------------------------------------------------------------------
package laiir_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int STATE_BITS  = 16;
   localparam int COEF_BITS   = 10;
   localparam int OUT_BITS    = 11;
   localparam int INDEX_BITS  = 2;
   localparam int PROD_BITS   = STATE_BITS + COEF_BITS;
   localparam int WIDE_BITS   = STATE_BITS + SAMPLE_BITS;
   localparam int FRAC_SHIFT  = SAMPLE_BITS - 1;

   localparam logic [INDEX_BITS-1:0] REG_A_SQUARED  = 2'd0;
   localparam logic [INDEX_BITS-1:0] REG_A_TIMES_B  = 2'd1;
   localparam logic [INDEX_BITS-1:0] REG_B_ZERO     = 2'd2;
   localparam logic [INDEX_BITS-1:0] REG_B_PLUS_AB  = 2'd3;

   localparam logic signed [COEF_BITS-1:0] RST_A_SQUARED = COEF_BITS'(13);
   localparam logic signed [COEF_BITS-1:0] RST_A_TIMES_B = COEF_BITS'(35);
   localparam logic signed [COEF_BITS-1:0] RST_B_ZERO    = COEF_BITS'(215);
   localparam logic signed [COEF_BITS-1:0] RST_B_PLUS_AB = COEF_BITS'(249);

   typedef logic signed [STATE_BITS-1:0] state_type;
   typedef logic signed [COEF_BITS-1:0]  coef_type;

   // Q9 product, arithmetic shift right, wrapped to the state width.
   function automatic state_type qmul(input state_type value, input coef_type coef);
      logic signed [PROD_BITS-1:0] prod;
      logic signed [PROD_BITS-1:0] shifted;
      prod    = PROD_BITS'(value) * PROD_BITS'(coef);
      shifted = prod >>> FRAC_SHIFT;
      return shifted[STATE_BITS-1:0];
   endfunction

endpackage

// ===== src/lookahead_first_order_iir.sv =====
// ----------------------------------------------------------------------------
// lookahead_first_order_iir
// A first-order IIR filter rewritten with look-ahead and pipelined taps. Each
// accepted sample updates the recursion and tap registers and yields one
// saturated 11-bit filtered sample, held in an output register until taken.
// One sample per cycle is accepted while the output is not stalled. The
// recursion closes through a single Q9 multiply-add; results move via the
// tap and partial-sum registers as samples are accepted. The user must write
// coefficients via the register port only with the filter idle; not enforced.
// ----------------------------------------------------------------------------
module lookahead_first_order_iir
   import laiir_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [OUT_BITS-1:0]    rsp_filtered_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [INDEX_BITS-1:0]         csr_index,
   input  logic signed [COEF_BITS-1:0]   csr_data
);

   localparam logic signed [STATE_BITS:0] OUT_MAX = (STATE_BITS+1)'(2**(OUT_BITS-1) - 1);
   localparam logic signed [STATE_BITS:0] OUT_MIN = -(STATE_BITS+1)'(2**(OUT_BITS-1));

   coef_type  coef_a_squared_ff, coef_a_times_b_ff, coef_b_zero_ff, coef_b_plus_ab_ff;
   state_type recursion_value_ff, recursion_delayed_ff;
   state_type tap_b_plus_ab_ff, tap_b_zero_ff, tap_feedback_ff, partial_sum_ff;
   state_type recursion_value_in, sample_ext;
   logic signed [WIDE_BITS-1:0] sample_wide;
   logic signed [STATE_BITS:0]  out_sum;
   logic signed [OUT_BITS-1:0]  filtered_in;
   logic signed [OUT_BITS-1:0]  rsp_filtered_out_ff;
   logic                        rsp_valid_ff;
   logic                        req_accept;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filtered_out = rsp_filtered_out_ff;

   assign sample_wide        = WIDE_BITS'(req_sample_in);
   assign sample_ext         = sample_wide[STATE_BITS-1:0];
   assign recursion_value_in = qmul(recursion_value_ff, coef_a_squared_ff) + sample_ext;

   always_comb begin
      out_sum = (STATE_BITS+1)'(partial_sum_ff) + (STATE_BITS+1)'(tap_b_zero_ff);
      if (out_sum > OUT_MAX) begin
         filtered_in = OUT_MAX[OUT_BITS-1:0];
      end else if (out_sum < OUT_MIN) begin
         filtered_in = OUT_MIN[OUT_BITS-1:0];
      end else begin
         filtered_in = out_sum[OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_squared_ff <= RST_A_SQUARED;
         coef_a_times_b_ff <= RST_A_TIMES_B;
         coef_b_zero_ff    <= RST_B_ZERO;
         coef_b_plus_ab_ff <= RST_B_PLUS_AB;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_A_SQUARED: coef_a_squared_ff <= csr_data;
            REG_A_TIMES_B: coef_a_times_b_ff <= csr_data;
            REG_B_ZERO:    coef_b_zero_ff    <= csr_data;
            REG_B_PLUS_AB: coef_b_plus_ab_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recursion_value_ff   <= '0;
         recursion_delayed_ff <= '0;
         tap_b_plus_ab_ff     <= '0;
         tap_b_zero_ff        <= '0;
         tap_feedback_ff      <= '0;
         partial_sum_ff       <= '0;
      end else if (req_accept) begin
         tap_b_zero_ff        <= qmul(recursion_value_ff, coef_b_zero_ff);
         partial_sum_ff       <= tap_b_plus_ab_ff + tap_feedback_ff;
         tap_b_plus_ab_ff     <= qmul(recursion_value_ff, coef_b_plus_ab_ff);
         tap_feedback_ff      <= qmul(recursion_delayed_ff, coef_a_times_b_ff);
         recursion_delayed_ff <= recursion_value_ff;
         recursion_value_ff   <= recursion_value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_filtered_out_ff <= filtered_in;
      end
   end

endmodule
